>>> rtl/poq_pkg.sv
package poq_pkg;

    localparam int PQ_CAPACITY = 16;
    localparam int TAG_W       = 8;
    localparam int PRI_W       = 8;
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;

    // Request kinds carried on the input beat.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } poq_entry_t;

    // Broadcast to every cell: what the whole row does this cycle.
    typedef struct packed {
        logic ins;
        logic rem;
    } poq_ctl_t;

endpackage

>>> rtl/priority_ordered_queue.sv
// Sorted priority queue of (tag, priority) entries built as a row of CAPACITY
// cells, with the head in cell 0. Every cell compares its own priority with that
// of an incoming entry in the same cycle, so an insert finds its place and the
// row shifts right at the clock edge that accepts it; a remove shifts it left the same way.
// Each request beat gives exactly one result beat, which appears on the m_
// channel in the cycle after the request is accepted; one request is taken every
// cycle for as long as the result side keeps up, the single output register
// being the only stage between the two channels. Higher priorities leave first
// and equal priorities leave in arrival order. A remove on an empty queue
// returns status 1 and an insert on a full queue returns status 2 with the entry
// dropped; in both cases the contents are unchanged. Tag and priority of a
// result are zero unless the beat returns a removed entry. Occupancy reports the
// number of stored entries after the request, truncated to five bits. The cell
// contents are not cleared by reset; only the fill count and output valid flag are.
module priority_ordered_queue #(
    parameter int CAPACITY = poq_pkg::PQ_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [poq_pkg::TAG_W-1:0]     s_entry_tag,
    input  logic [poq_pkg::PRI_W-1:0]     s_priority_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [poq_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_out_valid,
    output logic [poq_pkg::TAG_W-1:0]     m_out_tag,
    output logic [poq_pkg::PRI_W-1:0]     m_out_priority,
    output logic [poq_pkg::OCC_W-1:0]     m_occupancy
);
    import poq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fill count: cells below it hold valid entries.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Output register.
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    poq_entry_t          out_entry_reg;
    poq_entry_t          out_entry_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    logic        accept;
    logic        full;
    logic        empty;
    poq_ctl_t    ctl;
    poq_entry_t  new_entry;
    poq_entry_t  cell_q [CAPACITY];
    logic [CAPACITY-1:0] stay;

    // The input side is free whenever the output register is empty or is being
    // emptied in this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign ctl.ins = accept && (s_kind == KIND_INSERT) && !full;
    assign ctl.rem = accept && (s_kind == KIND_REMOVE) && !empty;

    assign new_entry.pri = s_priority_req;
    assign new_entry.tag = s_entry_tag;

    // The row of cells. Each cell sees its left neighbour's stay decision: the
    // first cell that does not stay, with a staying cell (or the head of the
    // row) to its left, takes the new entry; the cells behind it take their
    // left neighbour's entry. On a remove every cell takes its right neighbour.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        poq_entry_t left_e;
        poq_entry_t right_e;
        logic       left_s;
        logic       occ;

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_s = 1'b1;
        end else begin : g_body
            assign left_e = cell_q[i-1];
            assign left_s = stay[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_e = cell_q[i];
        end else begin : g_inner
            assign right_e = cell_q[i+1];
        end

        assign occ = (CNT_W'(i) < count_reg);

        poq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .occupied    (occ),
            .left_stay   (left_s),
            .entry       (cell_q[i]),
            .stay        (stay[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Result of the request accepted in this cycle.
    always_comb begin
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_entry_next = out_entry_reg;
        occ_next       = occ_reg;
        if (accept) begin
            m_valid_next   = 1'b1;
            status_next    = ST_OK;
            out_valid_next = 1'b0;
            out_entry_next = '0;
            occ_next       = OCC_W'(count_next);
            if (s_kind == KIND_REMOVE) begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    out_valid_next = 1'b1;
                    out_entry_next = cell_q[0];
                end
            end else if (full) begin
                status_next = ST_FULL;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg    <= status_next;
        out_valid_reg <= out_valid_next;
        out_entry_reg <= out_entry_next;
        occ_reg       <= occ_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_out_valid    = out_valid_reg;
    assign m_out_tag      = out_entry_reg.tag;
    assign m_out_priority = out_entry_reg.pri;
    assign m_occupancy    = occ_reg;

    // The fill count never runs past the number of cells.
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // The two leading cells, when both are filled, are in priority order.
    a_head_order : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_q[0].pri >= cell_q[1].pri))
        else $error("head cells out of priority order");

    // A beat that returns an entry always carries the ok status.
    a_out_status : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_valid) |-> (m_status == ST_OK))
        else $error("returned entry with an error status");

    // A stored insert grows the queue by exactly one entry.
    a_insert_count : assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue by one");

    // The input side is held off only while a result waits to be taken.
    a_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a waiting result");

endmodule

>>> rtl/poq_cell.sv
module poq_cell (
    input  logic                aclk,
    input  poq_pkg::poq_ctl_t   ctl,
    input  poq_pkg::poq_entry_t new_entry,
    input  poq_pkg::poq_entry_t left_entry,
    input  poq_pkg::poq_entry_t right_entry,
    input  logic                occupied,
    input  logic                left_stay,
    output poq_pkg::poq_entry_t entry,
    output logic                stay
);
    import poq_pkg::*;

    poq_entry_t entry_reg;
    poq_entry_t entry_next;

    // A stored entry of equal or higher priority holds its place on an insert.
    assign stay = occupied && (entry_reg.pri >= new_entry.pri);

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (!stay) begin
                entry_next = left_stay ? new_entry : left_entry;
            end
        end else if (ctl.rem) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
